// File: src/lpr_pkg.sv
package lpr_pkg;

   // Coordinate width of every endpoint and pixel field
   localparam int COORD_BITS = 12;

   // Opcodes of the request channel
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef struct packed {
      logic                         opcode;
      logic signed [COORD_BITS-1:0] x_start;
      logic signed [COORD_BITS-1:0] y_start;
      logic signed [COORD_BITS-1:0] x_end;
      logic signed [COORD_BITS-1:0] y_end;
      logic [7:0]                   line_color;
   } req_type;

   typedef struct packed {
      logic                         pixel_valid;
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic [7:0]                   pixel_color;
      logic                         last_pixel;
      logic                         line_empty;
   } rsp_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// File: src/lpr_div.sv
module lpr_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [2*lpr_pkg::COORD_BITS-1:0]     dividend,
   input  logic [lpr_pkg::COORD_BITS-1:0]       divisor,
   output lpr_pkg::div_sts_type                 sts,
   output logic [lpr_pkg::COORD_BITS-1:0]       quotient
);
   import lpr_pkg::*;

   localparam int CNT_BITS = $clog2(COORD_BITS);

   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [COORD_BITS-1:0] sh_ff, sh_in;
   logic [COORD_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;
   logic                  fits;

   // Trial subtract of one quotient bit
   always_comb begin
      trial = {rem_ff, sh_ff[COORD_BITS-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   // Load operands on start, then shift in one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         rem_in  = dividend[2*COORD_BITS-1:COORD_BITS];
         sh_in   = dividend[COORD_BITS-1:0];
         dvs_in  = divisor;
         cnt_in  = CNT_BITS'(COORD_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         sh_in  = {sh_ff[COORD_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = sh_ff;

endmodule

// File: src/line_pixel_rasterizer.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data  (lpr_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data  (lpr_pkg::rsp_type)
//
// A load, or a step with no active line, writes its result to the output
// register at acceptance.
// A pixel step holds the sequencer while the accepting cycle forms the offset,
// S_MUL does the multiply, the radix-2 divider runs, S_DIV sees its done flag
// and S_OUT forms the pixel.
// Reset is synchronous and leaves no line active.
// A stalled result holds in the output register and blocks new transactions;
// a finished pixel waits in the sequencer until that register frees.
module line_pixel_rasterizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpr_pkg::rsp_type  rsp_data
);
   import lpr_pkg::*;

   localparam int CB = COORD_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   function automatic logic [CB-1:0] mag_of(input logic signed [CB:0] v);
      logic signed [CB:0] a;
      a = (v < 0) ? -v : v;
      return a[CB-1:0];
   endfunction

   logic [1:0]           state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 line_active_ff, line_active_in;
   logic signed [CB-1:0] origin_x_ff, origin_x_in;
   logic signed [CB-1:0] origin_y_ff, origin_y_in;
   logic signed [CB:0]   delta_x_ff, delta_x_in;
   logic signed [CB:0]   delta_y_ff, delta_y_in;
   logic                 major_is_y_ff, major_is_y_in;
   logic signed [CB-1:0] major_current_ff, major_current_in;
   logic signed [CB-1:0] major_final_ff, major_final_in;
   logic [7:0]           held_color_ff, held_color_in;
   logic [CB-1:0]        off_mag_ff, off_mag_in;
   logic [CB-1:0]        minor_mag_ff, minor_mag_in;
   logic [CB-1:0]        major_mag_ff, major_mag_in;
   logic                 q_neg_ff, q_neg_in;
   logic signed [CB-1:0] pix_major_ff, pix_major_in;
   logic                 last_ff, last_in;

   logic                 req_take;
   logic                 rsp_free;
   logic signed [CB:0]   ld_dx, ld_dy;
   logic                 ld_major_y;
   logic signed [CB:0]   ld_major_delta;
   logic signed [CB:0]   st_major_delta, st_minor_delta, st_offset;
   logic signed [CB-1:0] st_major_origin;
   logic signed [CB-1:0] st_major_next;
   logic signed [CB:0]   q_signed;
   logic signed [CB-1:0] minor_coord;
   logic [2*CB-1:0]      product;
   div_sts_type          div_sts;
   logic [CB-1:0]        div_quo;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign req_take  = req_valid && req_ready;

   // Load-time deltas and major axis pick
   always_comb begin
      ld_dx = {req_data.x_end[CB-1], req_data.x_end}
            - {req_data.x_start[CB-1], req_data.x_start};
      ld_dy = {req_data.y_end[CB-1], req_data.y_end}
            - {req_data.y_start[CB-1], req_data.y_start};
      ld_major_y     = mag_of(ld_dy) > mag_of(ld_dx);
      ld_major_delta = ld_major_y ? ld_dy : ld_dx;
   end

   // Step-time offset along the major axis
   always_comb begin
      st_major_delta  = major_is_y_ff ? delta_y_ff : delta_x_ff;
      st_minor_delta  = major_is_y_ff ? delta_x_ff : delta_y_ff;
      st_major_origin = major_is_y_ff ? origin_y_ff : origin_x_ff;
      st_offset = {major_current_ff[CB-1], major_current_ff}
                - {st_major_origin[CB-1], st_major_origin};
      st_major_next = (st_major_delta > 0) ? major_current_ff + 1'b1
                                           : major_current_ff - 1'b1;
   end

   // Magnitude product feeds the divider registers
   assign product = off_mag_ff * minor_mag_ff;

   lpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_MUL),
      .dividend (product),
      .divisor  (major_mag_ff),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   // Signed quotient added to the minor origin
   always_comb begin
      q_signed    = q_neg_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      minor_coord = major_is_y_ff ? CB'(origin_x_ff + q_signed[CB-1:0])
                                  : CB'(origin_y_ff + q_signed[CB-1:0]);
   end

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;
      line_active_in   = line_active_ff;
      origin_x_in      = origin_x_ff;
      origin_y_in      = origin_y_ff;
      delta_x_in       = delta_x_ff;
      delta_y_in       = delta_y_ff;
      major_is_y_in    = major_is_y_ff;
      major_current_in = major_current_ff;
      major_final_in   = major_final_ff;
      held_color_in    = held_color_ff;
      off_mag_in       = off_mag_ff;
      minor_mag_in     = minor_mag_ff;
      major_mag_in     = major_mag_ff;
      q_neg_in         = q_neg_ff;
      pix_major_in     = pix_major_ff;
      last_in          = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_data.opcode == OP_LOAD) begin
                  origin_x_in      = req_data.x_start;
                  origin_y_in      = req_data.y_start;
                  delta_x_in       = ld_dx;
                  delta_y_in       = ld_dy;
                  major_is_y_in    = ld_major_y;
                  major_current_in = ld_major_y ? req_data.y_start : req_data.x_start;
                  major_final_in   = ld_major_y ? req_data.y_end : req_data.x_end;
                  held_color_in    = req_data.line_color;
                  line_active_in   = (ld_major_delta != 0);
                  rsp_in           = '0;
                  rsp_in.line_empty = (ld_major_delta == 0);
                  rsp_valid_in     = 1'b1;
               end else if (!line_active_ff) begin
                  rsp_in            = '0;
                  rsp_in.line_empty = 1'b1;
                  rsp_valid_in      = 1'b1;
               end else begin
                  off_mag_in       = mag_of(st_offset);
                  minor_mag_in     = mag_of(st_minor_delta);
                  major_mag_in     = mag_of(st_major_delta);
                  q_neg_in         = (st_offset < 0) ^ (st_minor_delta < 0)
                                   ^ (st_major_delta < 0);
                  pix_major_in     = major_current_ff;
                  major_current_in = st_major_next;
                  last_in          = (st_major_next == major_final_ff);
                  if (st_major_next == major_final_ff) begin
                     line_active_in = 1'b0;
                  end
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_sts.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_in.pixel_valid = 1'b1;
               rsp_in.pixel_x     = major_is_y_ff ? minor_coord : pix_major_ff;
               rsp_in.pixel_y     = major_is_y_ff ? pix_major_ff : minor_coord;
               rsp_in.pixel_color = held_color_ff;
               rsp_in.last_pixel  = last_ff;
               rsp_in.line_empty  = 1'b0;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         line_active_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         line_active_ff <= line_active_in;
      end
      rsp_ff           <= rsp_in;
      origin_x_ff      <= origin_x_in;
      origin_y_ff      <= origin_y_in;
      delta_x_ff       <= delta_x_in;
      delta_y_ff       <= delta_y_in;
      major_is_y_ff    <= major_is_y_in;
      major_current_ff <= major_current_in;
      major_final_ff   <= major_final_in;
      held_color_ff    <= held_color_in;
      off_mag_ff       <= off_mag_in;
      minor_mag_ff     <= minor_mag_in;
      major_mag_ff     <= major_mag_in;
      q_neg_ff         <= q_neg_in;
      pix_major_ff     <= pix_major_in;
      last_ff          <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A pixel step on an active line occupies the sequencer
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.opcode == OP_STEP && line_active_ff) |=> !req_ready)
      else $error("pixel step did not occupy the sequencer");

   // Divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide phase");

   // The final phase delivers a pixel result once the output register is free
   a_out_pixel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_free) |=>
         (rsp_valid && rsp_data.pixel_valid && !rsp_data.line_empty))
      else $error("pixel phase did not deliver a pixel");

endmodule

// File: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpr_pkg::*;

   localparam int TOTAL_ITEMS = 450;
   localparam int QUIET_FROM  = TOTAL_ITEMS - 60;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type exp;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Typed-in expectation that travels with the transaction on offer
   logic    typed_pending = 1'b0;
   rsp_type typed_result = '0;

   // Rasterizer state as the testbench sees it
   logic signed [COORD_BITS-1:0] org_x = '0;
   logic signed [COORD_BITS-1:0] org_y = '0;
   logic signed [COORD_BITS:0]   delta_x = '0;
   logic signed [COORD_BITS:0]   delta_y = '0;
   logic                         y_major = 1'b0;
   logic signed [COORD_BITS-1:0] cur_major = '0;
   logic signed [COORD_BITS-1:0] end_major = '0;
   logic                         line_live = 1'b0;
   logic [7:0]                   line_color = '0;

   rsp_type      pending_pixels[$];
   plan_row_type directed_plan[$];
   int           mismatch_count = 0;
   int           items_sent = 0;
   bit           quiet = 1'b0;
   bit           hold_request = 1'b0;

   line_pixel_rasterizer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the line state by one transaction and return the result it yields
   function automatic rsp_type advance_rasterizer(input req_type r);
      rsp_type res;
      int      xs, ys, xe, ye, dx, dy;
      int      span_major, span_minor, base_major, base_minor, minor, px, py;
      longint  travel, q;
      res = '0;
      if (r.opcode == OP_LOAD) begin
         xs = int'(r.x_start);
         ys = int'(r.y_start);
         xe = int'(r.x_end);
         ye = int'(r.y_end);
         dx = xe - xs;
         dy = ye - ys;
         org_x = COORD_BITS'(xs);
         org_y = COORD_BITS'(ys);
         delta_x = (COORD_BITS+1)'(dx);
         delta_y = (COORD_BITS+1)'(dy);
         y_major = (dy < 0 ? -dy : dy) > (dx < 0 ? -dx : dx);
         cur_major = y_major ? COORD_BITS'(ys) : COORD_BITS'(xs);
         end_major = y_major ? COORD_BITS'(ye) : COORD_BITS'(xe);
         line_color = r.line_color;
         line_live = ((y_major ? dy : dx) != 0);
         res.line_empty = !line_live;
      end else if (!line_live) begin
         res.line_empty = 1'b1;
      end else begin
         span_major = y_major ? int'(delta_y) : int'(delta_x);
         span_minor = y_major ? int'(delta_x) : int'(delta_y);
         base_major = y_major ? int'(org_y) : int'(org_x);
         base_minor = y_major ? int'(org_x) : int'(org_y);
         travel = longint'(cur_major) - longint'(base_major);
         // SV division truncates toward zero, as the pixel math requires
         q = (travel * longint'(span_minor)) / longint'(span_major);
         minor = base_minor + int'(q);
         px = y_major ? minor : int'(cur_major);
         py = y_major ? int'(cur_major) : minor;
         cur_major = COORD_BITS'(cur_major + ((span_major > 0) ? 1 : -1));
         res.pixel_valid = 1'b1;
         res.pixel_x = px[COORD_BITS-1:0];
         res.pixel_y = py[COORD_BITS-1:0];
         res.pixel_color = line_color;
         if (cur_major == end_major) begin
            res.last_pixel = 1'b1;
            line_live = 1'b0;
         end
      end
      return res;
   endfunction

   // Compare one result against its expectation, field by field
   task automatic check_pixel(input rsp_type e, input rsp_type a);
      if (a.pixel_valid !== e.pixel_valid) begin
         $error("pixel_valid: expected %0d, got %0d", e.pixel_valid, a.pixel_valid);
         mismatch_count++;
      end
      if (a.pixel_x !== e.pixel_x) begin
         $error("pixel_x: expected %0d, got %0d", $signed(e.pixel_x), $signed(a.pixel_x));
         mismatch_count++;
      end
      if (a.pixel_y !== e.pixel_y) begin
         $error("pixel_y: expected %0d, got %0d", $signed(e.pixel_y), $signed(a.pixel_y));
         mismatch_count++;
      end
      if (a.pixel_color !== e.pixel_color) begin
         $error("pixel_color: expected %0d, got %0d", e.pixel_color, a.pixel_color);
         mismatch_count++;
      end
      if (a.last_pixel !== e.last_pixel) begin
         $error("last_pixel: expected %0d, got %0d", e.last_pixel, a.last_pixel);
         mismatch_count++;
      end
      if (a.line_empty !== e.line_empty) begin
         $error("line_empty: expected %0d, got %0d", e.line_empty, a.line_empty);
         mismatch_count++;
      end
   endtask

   // Predict on every accepted request, check every accepted response
   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = advance_rasterizer(req_data);
            pending_pixels.push_back(typed_pending ? typed_result : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("unexpected transaction on rsp: pixel_x %0d pixel_y %0d",
                      $signed(rsp_data.pixel_x), $signed(rsp_data.pixel_y));
               mismatch_count++;
            end else begin
               check_pixel(pending_pixels.pop_front(), rsp_data);
            end
         end
      end
   end

   function automatic req_type line_load(input int xs, input int ys, input int xe,
                                         input int ye, input logic [7:0] color);
      req_type r;
      r.opcode = OP_LOAD;
      r.x_start = xs[COORD_BITS-1:0];
      r.y_start = ys[COORD_BITS-1:0];
      r.x_end = xe[COORD_BITS-1:0];
      r.y_end = ye[COORD_BITS-1:0];
      r.line_color = color;
      return r;
   endfunction

   // Step request with junk in the fields the block must ignore
   function automatic req_type step_req();
      req_type r;
      r = $bits(req_type)'({$urandom, $urandom});
      r.opcode = OP_STEP;
      return r;
   endfunction

   function automatic rsp_type pixel_at(input int x, input int y, input logic [7:0] color,
                                        input logic last);
      rsp_type r;
      r = '0;
      r.pixel_valid = 1'b1;
      r.pixel_x = x[COORD_BITS-1:0];
      r.pixel_y = y[COORD_BITS-1:0];
      r.pixel_color = color;
      r.last_pixel = last;
      return r;
   endfunction

   function automatic rsp_type no_line();
      rsp_type r;
      r = '0;
      r.line_empty = 1'b1;
      return r;
   endfunction

   function automatic void plan(input req_type r, input logic typed, input rsp_type e);
      directed_plan.push_back('{req: r, typed: typed, exp: e});
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   function automatic int clamp_coord(input int v);
      return (v > 2047) ? 2047 : ((v < -2048) ? -2048 : v);
   endfunction

   // Offer one transaction and hold it until accepted, then maybe idle
   task automatic send(input req_type r, input logic typed, input rsp_type e);
      req_valid <= 1'b1;
      req_data <= r;
      typed_pending <= typed;
      typed_result <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Receiver: random stalls, one long hold-off, none near the end
   initial begin
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      req_type r, junk;
      int      xs, ys, xe, ye, len, steps, span;
      bit      hold_done;
      hold_done = 1'b0;

      junk = '1;
      junk.opcode = OP_STEP;

      // Directed: no line, empty line, short lines both ways, extremes, reload
      plan(step_req(), 1'b1, no_line());
      plan(line_load(5, 5, 5, 5, 8'hAA), 1'b1, no_line());
      plan(junk, 1'b1, no_line());
      plan(line_load(0, 0, 3, 0, 8'hFF), 1'b1, '0);
      plan(step_req(), 1'b1, pixel_at(0, 0, 8'hFF, 1'b0));
      plan(junk, 1'b1, pixel_at(1, 0, 8'hFF, 1'b0));
      plan(step_req(), 1'b1, pixel_at(2, 0, 8'hFF, 1'b1));
      plan(step_req(), 1'b1, no_line());
      plan(line_load(-2048, 2047, 2047, -2048, 8'h00), 1'b1, '0);
      plan(junk, 1'b0, '0);
      plan(step_req(), 1'b0, '0);
      plan(line_load(0, 0, 0, -3, 8'h5A), 1'b1, '0);
      plan(step_req(), 1'b1, pixel_at(0, 0, 8'h5A, 1'b0));
      plan(step_req(), 1'b1, pixel_at(0, -1, 8'h5A, 1'b0));
      plan(step_req(), 1'b1, pixel_at(0, -2, 8'h5A, 1'b1));
      plan(line_load(10, -7, -3, 20, 8'hA5), 1'b0, '0);
      plan(step_req(), 1'b0, '0);
      plan(step_req(), 1'b0, '0);
      plan(line_load(-2048, -2048, -2046, 2047, 8'h3C), 1'b0, '0);
      plan(step_req(), 1'b0, '0);
      plan(step_req(), 1'b0, '0);
      plan(line_load(-1, -1, -2048, -5, 8'hC3), 1'b0, '0);
      plan(step_req(), 1'b0, '0);
      plan(step_req(), 1'b0, '0);
      plan(line_load(2047, 2047, -2048, -2048, 8'h81), 1'b0, '0);
      plan(step_req(), 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         send(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].exp);

      // Random: mostly complete short lines, some noise and aborted lines
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= QUIET_FROM)
            quiet = 1'b1;
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_request = 1'b1;
            hold_done = 1'b1;
         end
         case ($urandom_range(0, 9))
            0: begin
               r = line_load(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             8'($urandom));
               send(r, 1'b0, '0);
               repeat ($urandom_range(0, 3)) send(step_req(), 1'b0, '0);
            end
            1: begin
               repeat ($urandom_range(1, 3)) send(step_req(), 1'b0, '0);
            end
            default: begin
               span = ($urandom_range(0, 7) == 0) ? 120 : 24;
               xs = rand_coord();
               ys = rand_coord();
               xe = clamp_coord(xs + $urandom_range(0, 2 * span) - span);
               ye = clamp_coord(ys + $urandom_range(0, 2 * span) - span);
               len = (xe > xs ? xe - xs : xs - xe);
               if ((ye > ys ? ye - ys : ys - ye) > len)
                  len = (ye > ys ? ye - ys : ys - ye);
               if ($urandom_range(0, 5) == 0)
                  steps = $urandom_range(0, len);
               else
                  steps = len + $urandom_range(0, 2);
               // Keep the run close to its planned length
               if (steps > TOTAL_ITEMS - items_sent - 1)
                  steps = TOTAL_ITEMS - items_sent - 1;
               send(line_load(xs, ys, xe, ye, 8'($urandom)), 1'b0, '0);
               repeat (steps) send(step_req(), 1'b0, '0);
            end
         endcase
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then allow the pipeline to settle
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
